// ----- rtl/lirs_pkg.sv -----
// Shared constants, register codes and control types of the resampler.
`timescale 1ns / 1ps

package lirs_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS  = 16;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_UPSAMPLE = 64;
   localparam int STEP_BITS    = 20;
   localparam int OUT_CNT_BITS = 16;
   localparam int POINT_BITS   = OUT_CNT_BITS + 1;
   localparam int ACC_BITS     = STEP_BITS + 1;
   localparam int RUN_BITS     = $clog2(MAX_UPSAMPLE + 1);
   localparam int CSR_IDX_BITS = 2;
   localparam int PROD_BITS    = SAMPLE_BITS + FRAC_BITS + 2;

   // One whole sample step in position units
   localparam logic [ACC_BITS-1:0] ONE_POS = ACC_BITS'(1) << FRAC_BITS;
   // Smallest usable step; bounds a run to MAX_UPSAMPLE points
   localparam logic [STEP_BITS-1:0] MIN_STEP =
      STEP_BITS'(((2 ** FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);

   // Register reset values
   localparam logic                    MODE_RESET  = 1'b1;
   localparam logic [STEP_BITS-1:0]    STEP_RESET  = STEP_BITS'(65536);
   localparam logic [OUT_CNT_BITS-1:0] COUNT_RESET = OUT_CNT_BITS'(256);

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODE  = 2'd0,
      CSR_STEP  = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic idle;
      logic take_first;
      logic mark_done;
      logic start_run;
      logic emit;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic grid_done;
      logic grid_full;
      logic need_first;
      logic can_emit;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/linear_interpolation_resampler_unit.sv -----
// Top level of the linear interpolation / zero-order hold resampler.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_sample_in
//   rsp_      out        rsp_valid/rsp_stall  rsp_grid_value, rsp_run_end, rsp_grid_end
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// An item that causes a run of grid points (up to 64) is handled in steps: the accept cycle,
// one grid point per cycle into the output register while rsp_ is not stalled, and a step
// to close the run. Items that cause no run (grid finished, first sample of linear mode)
// are handled in the accept cycle and start no run.
// Synchronous reset restores the register defaults and restarts the grid.
// A stall on rsp_ holds the output register and pauses the run; req_ is taken only between
// runs, and register writes are taken at the same times while no input item is offered.
`timescale 1ns / 1ps

module linear_interpolation_resampler_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [lirs_pkg::SAMPLE_BITS-1:0] rsp_grid_value,
   output logic                                    rsp_run_end,
   output logic                                    rsp_grid_end,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lirs_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [lirs_pkg::STEP_BITS-1:0]          csr_data
);

   lirs_pkg::cmd_type    cmd;
   lirs_pkg::status_type status;
   logic                 csr_write;

   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   lirs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .csr_valid      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_grid_value (rsp_grid_value),
      .rsp_run_end    (rsp_run_end),
      .rsp_grid_end   (rsp_grid_end)
   );

   // Take register writes only between runs, and never beside an input item
   assign csr_ready = cmd.idle && !req_valid;
   assign csr_write = csr_valid && csr_ready;

endmodule

// ----- rtl/lirs_datapath.sv -----
// Datapath of the resampler: registers, grid position, interpolation and output stage.
`timescale 1ns / 1ps

module lirs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lirs_pkg::cmd_type                     cmd,
   output lirs_pkg::status_type                  status,
   input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                  csr_valid,
   input  logic [lirs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [lirs_pkg::STEP_BITS-1:0]        csr_data,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [lirs_pkg::SAMPLE_BITS-1:0] rsp_grid_value,
   output logic                                  rsp_run_end,
   output logic                                  rsp_grid_end
);

   // Configuration registers
   logic                                  mode_ff, mode_in;
   logic [lirs_pkg::STEP_BITS-1:0]        step_ff, step_in;
   logic [lirs_pkg::OUT_CNT_BITS-1:0]     count_ff, count_in;

   // Grid state
   logic signed [lirs_pkg::SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [lirs_pkg::SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic                                  have_ff, have_in;
   logic [lirs_pkg::ACC_BITS-1:0]         acc_ff, acc_in;
   logic [lirs_pkg::POINT_BITS-1:0]       points_ff, points_in;
   logic                                  done_ff, done_in;
   logic [lirs_pkg::RUN_BITS-1:0]         run_ff, run_in;

   // Output stage
   logic                                  out_valid_ff, out_valid_in;
   logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_value_ff, out_value_in;
   logic                                  out_run_end_ff, out_run_end_in;
   logic                                  out_grid_end_ff, out_grid_end_in;

   // Combinational helpers
   logic                                  cfg_we;
   logic [lirs_pkg::POINT_BITS-1:0]       total;
   logic [lirs_pkg::POINT_BITS-1:0]       points_plus;
   logic [lirs_pkg::STEP_BITS-1:0]        step_eff;
   logic [lirs_pkg::ACC_BITS-1:0]         acc_next;
   logic                                  acc_lt_one;
   logic                                  points_lt_total;
   logic                                  emit_last;
   logic                                  out_free;
   logic signed [lirs_pkg::SAMPLE_BITS:0] diff;
   logic signed [lirs_pkg::FRAC_BITS:0]   frac;
   logic signed [lirs_pkg::PROD_BITS-1:0] prod;
   logic signed [lirs_pkg::SAMPLE_BITS+1:0] interp_delta;
   logic signed [lirs_pkg::SAMPLE_BITS+1:0] interp_sum;
   logic signed [lirs_pkg::SAMPLE_BITS-1:0] point_value;

   // Decode register write
   assign cfg_we = csr_valid && cmd.idle &&
                   ((csr_index == lirs_pkg::CSR_MODE) ||
                    (csr_index == lirs_pkg::CSR_STEP) ||
                    (csr_index == lirs_pkg::CSR_COUNT));

   // Grid bookkeeping
   assign total = mode_ff ? {1'b0, count_ff}
                          : {1'b0, count_ff} + lirs_pkg::POINT_BITS'(1);
   assign points_plus     = points_ff + lirs_pkg::POINT_BITS'(1);
   assign step_eff        = (step_ff < lirs_pkg::MIN_STEP) ? lirs_pkg::MIN_STEP : step_ff;
   assign acc_next        = acc_ff + lirs_pkg::ACC_BITS'(step_eff);
   assign acc_lt_one      = acc_ff < lirs_pkg::ONE_POS;
   assign points_lt_total = points_ff < total;
   assign emit_last       = (points_plus >= total) || (acc_next >= lirs_pkg::ONE_POS) ||
                            (run_ff == lirs_pkg::RUN_BITS'(lirs_pkg::MAX_UPSAMPLE - 1));
   assign out_free        = !out_valid_ff || !rsp_stall;

   // Interpolate: prev + floor((cur - prev) * frac / 2^FRAC_BITS)
   assign diff  = {cur_ff[lirs_pkg::SAMPLE_BITS-1], cur_ff} -
                  {prev_ff[lirs_pkg::SAMPLE_BITS-1], prev_ff};
   assign frac  = {1'b0, acc_ff[lirs_pkg::FRAC_BITS-1:0]};
   assign prod  = diff * frac;
   assign interp_delta = prod[lirs_pkg::PROD_BITS-1:lirs_pkg::FRAC_BITS];
   assign interp_sum   = {{2{prev_ff[lirs_pkg::SAMPLE_BITS-1]}}, prev_ff} + interp_delta;
   assign point_value  = mode_ff ? interp_sum[lirs_pkg::SAMPLE_BITS-1:0] : cur_ff;

   // Report status
   always_comb begin
      status            = '0;
      status.grid_done  = done_ff;
      status.grid_full  = !points_lt_total;
      status.need_first = mode_ff && !have_ff;
      status.can_emit   = points_lt_total && acc_lt_one &&
                          (run_ff != lirs_pkg::RUN_BITS'(lirs_pkg::MAX_UPSAMPLE));
      status.out_free   = out_free;
   end

   // Next state of registers and grid
   always_comb begin
      mode_in   = mode_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      have_in   = have_ff;
      acc_in    = acc_ff;
      points_in = points_ff;
      done_in   = done_ff;
      run_in    = run_ff;
      if (cfg_we) begin
         case (csr_index)
            lirs_pkg::CSR_MODE:  mode_in  = csr_data[0];
            lirs_pkg::CSR_STEP:  step_in  = csr_data;
            lirs_pkg::CSR_COUNT: count_in = csr_data[lirs_pkg::OUT_CNT_BITS-1:0];
            default: ;
         endcase
         // Restart the grid
         have_in   = 1'b0;
         acc_in    = '0;
         points_in = '0;
         done_in   = 1'b0;
      end else begin
         if (cmd.take_first) begin
            prev_in = req_sample_in;
            have_in = 1'b1;
         end
         if (cmd.mark_done) begin
            done_in = 1'b1;
         end
         if (cmd.start_run) begin
            cur_in = req_sample_in;
            run_in = '0;
         end
         if (cmd.emit) begin
            points_in = points_plus;
            acc_in    = acc_next;
            run_in    = run_ff + lirs_pkg::RUN_BITS'(1);
         end
         if (cmd.finish) begin
            if (!points_lt_total) begin
               done_in = 1'b1;
            end else if (!acc_lt_one) begin
               acc_in = acc_ff - lirs_pkg::ONE_POS;
            end else begin
               acc_in = '0;
            end
            prev_in = cur_ff;
            have_in = 1'b1;
         end
      end
   end

   // Load the output stage on emit, drop it when taken
   always_comb begin
      out_valid_in    = out_valid_ff && rsp_stall;
      out_value_in    = out_value_ff;
      out_run_end_in  = out_run_end_ff;
      out_grid_end_in = out_grid_end_ff;
      if (cmd.emit) begin
         out_valid_in    = 1'b1;
         out_value_in    = point_value;
         out_run_end_in  = emit_last;
         out_grid_end_in = (points_plus == total);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lirs_pkg::MODE_RESET;
         step_ff      <= lirs_pkg::STEP_RESET;
         count_ff     <= lirs_pkg::COUNT_RESET;
         have_ff      <= 1'b0;
         acc_ff       <= '0;
         points_ff    <= '0;
         done_ff      <= 1'b0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         have_ff      <= have_in;
         acc_ff       <= acc_in;
         points_ff    <= points_in;
         done_ff      <= done_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prev_ff         <= prev_in;
      cur_ff          <= cur_in;
      out_value_ff    <= out_value_in;
      out_run_end_ff  <= out_run_end_in;
      out_grid_end_ff <= out_grid_end_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_grid_value = out_value_ff;
   assign rsp_run_end    = out_run_end_ff;
   assign rsp_grid_end   = out_grid_end_ff;

endmodule

// ----- rtl/lirs_ctrl.sv -----
// Controller of the resampler: accepts items and sequences each run of grid points.
`timescale 1ns / 1ps

module lirs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd,
   output logic                 req_stall
);

   lirs_pkg::state_type state_ff, state_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         lirs_pkg::ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               if (status.grid_done) begin
                  // drop the item, grid is finished
               end else if (status.grid_full) begin
                  cmd.mark_done = 1'b1;
               end else if (status.need_first) begin
                  cmd.take_first = 1'b1;
               end else begin
                  cmd.start_run = 1'b1;
                  state_in      = lirs_pkg::ST_RUN;
               end
            end
         end
         lirs_pkg::ST_RUN: begin
            if (status.can_emit) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.finish = 1'b1;
               state_in   = lirs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lirs_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lirs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = !cmd.idle;

endmodule

// ----- rtl/lirs_checker.sv -----
// Port-level checks of the resampler and their binding to the top level.
`timescale 1ns / 1ps

module lirs_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [lirs_pkg::SAMPLE_BITS-1:0] rsp_grid_value,
   input logic                                    rsp_run_end,
   input logic                                    rsp_grid_end,
   input logic                                    csr_ready
);

   // Stalled item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_grid_value) &&
                                 $stable(rsp_run_end) && $stable(rsp_grid_end))
      else $error("stalled result item changed");

   // Last point of the grid always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_end |-> rsp_run_end)
      else $error("grid end without run end");

   // Register port opens only while the input port is open
   assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("register port open during a run");

   // Come out of reset ready for an item
   assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind linear_interpolation_resampler_unit lirs_checker u_checker (.*);

// ----- tb/sv/grid_point_checker.sv -----
// Checker for the resampler: predicts every grid point and compares it with the output channel.
`timescale 1ns / 1ps

module grid_point_checker
   import lirs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0] rsp_grid_value,
   input  logic                          rsp_run_end,
   input  logic                          rsp_grid_end,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [STEP_BITS-1:0]          csr_data,
   output int                            error_count,
   output int                            pending_count,
   output logic                          grid_closed
);

   localparam int POS_BITS = 22;
   localparam logic [POS_BITS-1:0] ONE_WHOLE = POS_BITS'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          run_end;
      logic                          grid_end;
   } grid_point_type;

   grid_point_type pending_points[$];
   grid_point_type oldest;

   // Model copy of the registers
   logic                    linear_mode;
   logic [STEP_BITS-1:0]    step_reg;
   logic [OUT_CNT_BITS-1:0] count_reg;

   // Model copy of the grid state
   logic signed [SAMPLE_BITS-1:0] prev_sample;
   logic                          have_prev;
   logic [POS_BITS-1:0]           position;
   logic [POINT_BITS-1:0]         points_out;

   task automatic restart_grid();
      prev_sample = '0;
      have_prev   = 1'b0;
      position    = '0;
      points_out  = '0;
      grid_closed = 1'b0;
   endtask

   // Work out the run of grid points that one accepted sample causes
   task automatic predict_grid_points(input logic signed [SAMPLE_BITS-1:0] sample);
      logic [POINT_BITS-1:0]         total;
      logic [POS_BITS-1:0]           used_step;
      longint                        product;
      logic signed [SAMPLE_BITS-1:0] value;
      grid_point_type                point;
      int                            n;
      n = 0;
      if (grid_closed)
         return;
      total = linear_mode ? POINT_BITS'(count_reg)
                          : POINT_BITS'(count_reg) + POINT_BITS'(1);
      if (points_out >= total) begin
         grid_closed = 1'b1;
         return;
      end
      // first sample of linear mode only opens the interval
      if (linear_mode && !have_prev) begin
         prev_sample = sample;
         have_prev   = 1'b1;
         return;
      end
      used_step = (step_reg < MIN_STEP) ? POS_BITS'(MIN_STEP) : POS_BITS'(step_reg);
      while (n < MAX_UPSAMPLE && points_out < total && position < ONE_WHOLE) begin
         if (linear_mode) begin
            product = (longint'(sample) - longint'(prev_sample)) * longint'(position);
            value   = SAMPLE_BITS'(longint'(prev_sample) + (product >>> FRAC_BITS));
         end else begin
            value = sample;
         end
         point.value    = value;
         point.grid_end = (points_out + POINT_BITS'(1) == total);
         points_out     = points_out + POINT_BITS'(1);
         position       = position + used_step;
         n++;
         point.run_end  = !(n < MAX_UPSAMPLE && points_out < total && position < ONE_WHOLE);
         pending_points = {pending_points, point};
      end
      // move the position to the next reference sample
      if (points_out >= total)
         grid_closed = 1'b1;
      else if (position >= ONE_WHOLE)
         position = position - ONE_WHOLE;
      else
         position = '0;
      prev_sample = sample;
      have_prev   = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         linear_mode = MODE_RESET;
         step_reg    = STEP_RESET;
         count_reg   = COUNT_RESET;
         restart_grid();
         pending_points.delete();
      end else begin
         // apply register writes; a spare index leaves the grid alone
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE: begin
                  linear_mode = csr_data[0];
                  restart_grid();
               end
               CSR_STEP: begin
                  step_reg = csr_data;
                  restart_grid();
               end
               CSR_COUNT: begin
                  count_reg = csr_data[OUT_CNT_BITS-1:0];
                  restart_grid();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_grid_points(req_sample_in);
         // compare each output item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_points.size() == 0) begin
               error_count++;
               $display("%0t: unexpected output item, grid_value %0d run_end %0b grid_end %0b",
                        $time, rsp_grid_value, rsp_run_end, rsp_grid_end);
            end else begin
               oldest = pending_points.pop_front();
               if (rsp_grid_value !== oldest.value) begin
                  error_count++;
                  $display("%0t: grid_value expected %0d, actual %0d",
                           $time, oldest.value, rsp_grid_value);
               end
               if (rsp_run_end !== oldest.run_end) begin
                  error_count++;
                  $display("%0t: run_end expected %0b, actual %0b",
                           $time, oldest.run_end, rsp_run_end);
               end
               if (rsp_grid_end !== oldest.grid_end) begin
                  error_count++;
                  $display("%0t: grid_end expected %0b, actual %0b",
                           $time, oldest.grid_end, rsp_grid_end);
               end
            end
         end
      end
      pending_count = pending_points.size();
   end

endmodule

// ----- tb/sv/linear_interpolation_resampler_unit_test.sv -----
// Top of the resampler testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module linear_interpolation_resampler_unit_test;
   import lirs_pkg::*;

   localparam int RANDOM_ITEMS  = 96;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_grid_value;
   logic                          rsp_run_end;
   logic                          rsp_grid_end;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [STEP_BITS-1:0]          csr_data;

   int   error_count;
   int   pending_count;
   logic grid_closed;

   int                            burst_left;
   bit                            gaps_on;
   logic signed [SAMPLE_BITS-1:0] last_sample;

   linear_interpolation_resampler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grid_value (rsp_grid_value),
      .rsp_run_end    (rsp_run_end),
      .rsp_grid_end   (rsp_grid_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   grid_point_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grid_value (rsp_grid_value),
      .rsp_run_end    (rsp_run_end),
      .rsp_grid_end   (rsp_grid_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .grid_closed    (grid_closed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the output channel in segments of changing style
   initial begin : stall_pattern
      stall_style_type style;
      int              seg_left;
      rsp_stall = 1'b0;
      style     = STALL_NONE;
      seg_left  = 0;
      forever begin
         @(negedge clock);
         if (seg_left == 0) begin
            style    = stall_style_type'($urandom_range(0, 3));
            seg_left = $urandom_range(16, 160);
         end
         seg_left--;
         case (style)
            STALL_NONE:  rsp_stall = 1'b0;
            STALL_LIGHT: rsp_stall = ($urandom_range(0, 9) < 3);
            STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 8);
            default:     rsp_stall = (seg_left % 3 == 0);
         endcase
      end
   end

   // End a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Write one register and wait for the handshake
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [STEP_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop valid, wait for every predicted point, then let the block go quiet
   task automatic drain();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic linear, input logic [STEP_BITS-1:0] step,
                            input logic [STEP_BITS-1:0] count);
      logic [STEP_BITS-1:0] pad;
      pad = STEP_BITS'($urandom);
      drain();
      write_reg(CSR_MODE, {pad[STEP_BITS-1:1], linear});
      write_reg(CSR_STEP, step);
      write_reg(CSR_COUNT, count);
   endtask

   // Send one sample item; bursts alternate with random gaps while gaps_on is set
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         if (gaps_on)
            repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid     = 1'b1;
      req_sample_in = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // Mix full-range samples, extremes and slow ramps
   function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
      logic signed [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 5))
         0: value = 16'sh7FFF;
         1: value = 16'sh8000;
         2: value = last_sample + SAMPLE_BITS'($urandom_range(0, 64)) - 16'sd32;
         default: value = SAMPLE_BITS'($urandom);
      endcase
      last_sample = value;
      return value;
   endfunction

   initial begin : stimulus
      logic [STEP_BITS-1:0] step;
      logic [STEP_BITS-1:0] count;
      logic [STEP_BITS-1:0] pad;
      int                   useful;
      int                   per_phase;
      int                   k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_MODE;
      csr_data      = '0;
      burst_left    = 0;
      gaps_on       = 1'b1;
      last_sample   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults: linear mode, unit step, extremes
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);

      // Step under the minimum: full runs between extremes
      configure(1'b1, 20'd1000, 20'd300);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // Zero-order hold on a short grid; late samples are dropped
      configure(1'b0, 20'h18000, 20'd3);
      send_sample(16'sd5);
      send_sample(-16'sd5);
      send_sample(16'sd100);
      send_sample(16'sd200);
      send_sample(16'sd300);
      send_sample(16'sd400);

      // Zero out_count in both modes
      configure(1'b1, 20'h08000, 20'd0);
      send_sample(16'sd1);
      send_sample(16'sd2);
      configure(1'b0, 20'h08000, 20'd0);
      send_sample(16'sd7);
      send_sample(16'sd8);

      // Largest step; a spare register index must not restart the grid
      configure(1'b1, 20'hFFFFF, 20'd4);
      send_sample(16'sd100);
      send_sample(-16'sd100);
      drain();
      pad = STEP_BITS'($urandom);
      write_reg(CSR_SPARE, pad);
      send_sample(16'sd50);
      send_sample(-16'sd50);
      send_sample(16'sd25);

      // Random phases with random settings
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         pad = STEP_BITS'($urandom);
         case ($urandom_range(0, 5))
            0: step = STEP_BITS'($urandom_range(0, MIN_STEP - 1));
            1: step = STEP_BITS'($urandom_range(MIN_STEP, 65536));
            2: step = STEP_BITS'($urandom_range(65536, 262144));
            3: step = 20'hFFFFF;
            4: step = pad;
            default: step = MIN_STEP;
         endcase
         pad = STEP_BITS'($urandom);
         case ($urandom_range(0, 7))
            0: count = pad & 20'hF0000;
            1: count = 20'h0FFFF;
            2: count = pad;
            default: count = STEP_BITS'($urandom_range(1, 300));
         endcase
         configure(1'($urandom_range(0, 1)), step, count);
         gaps_on   = ($urandom_range(0, 3) != 0);
         per_phase = $urandom_range(8, 30);
         k = 0;
         while (k < per_phase && useful < RANDOM_ITEMS && !grid_closed) begin
            send_sample(next_sample());
            k++;
            useful++;
         end
         // poke a finished grid with a few more samples
         if (grid_closed)
            repeat ($urandom_range(1, 3)) send_sample(SAMPLE_BITS'($urandom));
      end

      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lirs_pkg.sv
rtl/lirs_datapath.sv
rtl/lirs_ctrl.sv
rtl/linear_interpolation_resampler_unit.sv
rtl/lirs_checker.sv
tb/sv/grid_point_checker.sv
tb/sv/linear_interpolation_resampler_unit_test.sv
